// File: rtl/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared types and constants for the WebSocket frame deframer: result
// layout, result kinds, frame types and the width of the length counter.
// ----------------------------------------------------------------------------
package wsfd_pkg;

    localparam int LENGTH_BITS = 63;
    localparam int FLEN_W      = 63;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    localparam logic [1:0] FT_TEXT  = 2'd0;
    localparam logic [1:0] FT_PING  = 2'd1;
    localparam logic [1:0] FT_PONG  = 2'd2;
    localparam logic [1:0] FT_CLOSE = 2'd3;

    localparam logic ERR_NOT_FINAL = 1'b0;
    localparam logic ERR_BAD_OPC   = 1'b1;

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        frame_type;
        logic [7:0]        data_byte;
        logic              last;
        logic [FLEN_W-1:0] frame_length;
        logic [15:0]       close_code;
        logic              fault_code;
    } result_t;

endpackage

// File: rtl/wsfd_parser.sv
// ----------------------------------------------------------------------------
// wsfd_parser
// Frame state registers and the per-byte next-state and result logic.
// ----------------------------------------------------------------------------
module wsfd_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       rx_byte,
    output logic             res_valid,
    output wsfd_pkg::result_t res
);
    import wsfd_pkg::*;

    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXT16   = 3'd2;
    localparam logic [2:0] PH_EXT64   = 3'd3;
    localparam logic [2:0] PH_MASK    = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_DROP    = 3'd6;

    logic [2:0]             phase_reg, phase_next;
    logic [1:0]             opcode_reg, opcode_next;
    logic                   masked_reg, masked_next;
    logic [LENGTH_BITS-1:0] remain_reg, remain_next;
    logic [2:0]             hcount_reg, hcount_next;
    logic [31:0]            key_reg, key_next;
    logic [1:0]             midx_reg, midx_next;
    logic [15:0]            cstat_reg, cstat_next;

    logic                   len_done;
    logic                   hdr_done;
    logic [7:0]             key_byte;
    logic [7:0]             data;
    logic [2:0]             hc_inc;
    logic [2:0]             need;

    always_comb
    begin
        unique case (midx_reg)
            2'd0: key_byte = key_reg[31:24];
            2'd1: key_byte = key_reg[23:16];
            2'd2: key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    assign data   = rx_byte ^ (masked_reg ? key_byte : 8'h00);
    assign hc_inc = hcount_reg + 3'd1;
    assign need   = (phase_reg == PH_EXT16) ? 3'd2 : 3'd0;

    always_comb
    begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        masked_next = masked_reg;
        remain_next = remain_reg;
        hcount_next = hcount_reg;
        key_next    = key_reg;
        midx_next   = midx_reg;
        cstat_next  = cstat_reg;
        len_done    = 1'b0;
        hdr_done    = 1'b0;
        res_valid   = 1'b0;
        res         = '0;

        unique case (phase_reg)
            PH_HDR0:
            begin
                if (!rx_byte[7])
                begin
                    phase_next     = PH_DROP;
                    res_valid      = 1'b1;
                    res.kind       = KIND_ERROR;
                    res.fault_code = ERR_NOT_FINAL;
                end
                else
                begin
                    phase_next = PH_HDR1;
                    unique case (rx_byte[3:0])
                        4'h1: opcode_next = FT_TEXT;
                        4'h9: opcode_next = FT_PING;
                        4'hA: opcode_next = FT_PONG;
                        4'h8: opcode_next = FT_CLOSE;
                        default:
                        begin
                            phase_next     = PH_DROP;
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.fault_code = ERR_BAD_OPC;
                        end
                    endcase
                end
            end
            PH_HDR1:
            begin
                masked_next = rx_byte[7];
                key_next    = '0;
                hcount_next = '0;
                remain_next = '0;
                if (rx_byte[6:0] == 7'd126)
                    phase_next = PH_EXT16;
                else if (rx_byte[6:0] == 7'd127)
                    phase_next = PH_EXT64;
                else
                begin
                    remain_next = LENGTH_BITS'(rx_byte[6:0]);
                    len_done    = 1'b1;
                end
            end
            PH_EXT16, PH_EXT64:
            begin
                remain_next = {remain_reg[LENGTH_BITS-9:0], rx_byte};
                hcount_next = hc_inc;
                len_done    = (hc_inc == need);
            end
            PH_MASK:
            begin
                key_next    = {key_reg[23:0], rx_byte};
                hcount_next = hc_inc;
                hdr_done    = (hc_inc == 3'd4);
            end
            PH_PAYLOAD:
            begin
                midx_next = midx_reg + 2'd1;
                if (remain_reg != '0)
                    remain_next = remain_reg - LENGTH_BITS'(1);
                if (remain_next == '0)
                    phase_next = PH_HDR0;
                if (opcode_reg == FT_CLOSE)
                begin
                    if (hcount_reg == 3'd0)
                    begin
                        cstat_next  = {data, 8'h00};
                        hcount_next = 3'd1;
                    end
                    else if (hcount_reg == 3'd1)
                    begin
                        cstat_next  = {cstat_reg[15:8], data};
                        hcount_next = 3'd2;
                    end
                    if (remain_next == '0)
                    begin
                        res_valid      = 1'b1;
                        res.kind       = KIND_CLOSE;
                        res.close_code = (hcount_next >= 3'd2) ? cstat_next : 16'h0000;
                    end
                end
                else if (opcode_reg != FT_PONG)
                begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_DATA;
                    res.frame_type = opcode_reg;
                    res.data_byte  = data;
                    res.last       = (remain_next == '0);
                end
            end
            default:
                phase_next = PH_DROP;
        endcase

        if (len_done)
        begin
            hcount_next = '0;
            if (masked_next)
                phase_next = PH_MASK;
            else
                hdr_done = 1'b1;
        end

        if (hdr_done)
        begin
            midx_next   = '0;
            hcount_next = '0;
            cstat_next  = '0;
            if (remain_next == '0)
            begin
                phase_next = PH_HDR0;
                if (opcode_next == FT_TEXT || opcode_next == FT_PING)
                begin
                    res_valid      = 1'b1;
                    res.kind       = KIND_START;
                    res.frame_type = opcode_next;
                    res.last       = 1'b1;
                end
                else if (opcode_next == FT_CLOSE)
                begin
                    res_valid = 1'b1;
                    res.kind  = KIND_CLOSE;
                end
            end
            else
            begin
                phase_next = PH_PAYLOAD;
                if (opcode_next == FT_TEXT || opcode_next == FT_PING)
                begin
                    res_valid        = 1'b1;
                    res.kind         = KIND_START;
                    res.frame_type   = opcode_next;
                    res.frame_length = FLEN_W'(remain_next);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            opcode_reg <= '0;
            masked_reg <= 1'b0;
            remain_reg <= '0;
            hcount_reg <= '0;
            key_reg    <= '0;
            midx_reg   <= '0;
            cstat_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            masked_reg <= masked_next;
            remain_reg <= remain_next;
            hcount_reg <= hcount_next;
            key_reg    <= key_next;
            midx_reg   <= midx_next;
            cstat_reg  <= cstat_next;
        end
    end

endmodule

// File: rtl/wsfd_out_buf.sv
// ----------------------------------------------------------------------------
// wsfd_out_buf
// Result register with a skid entry; input ready is taken from a register.
// ----------------------------------------------------------------------------
module wsfd_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  wsfd_pkg::result_t push_data,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output wsfd_pkg::result_t out_data
);
    import wsfd_pkg::*;

    logic    ovalid_reg;
    logic    svalid_reg;
    result_t odata_reg;
    result_t sdata_reg;
    logic    pop;

    assign pop       = ovalid_reg & out_ready;
    assign room      = !svalid_reg;
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            svalid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (svalid_reg)
                svalid_reg <= 1'b0;
            else if (!push)
                ovalid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (!ovalid_reg)
                ovalid_reg <= 1'b1;
            else
                svalid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (svalid_reg)
                odata_reg <= sdata_reg;
            else if (push)
                odata_reg <= push_data;
        end
        else if (push)
        begin
            if (!ovalid_reg)
                odata_reg <= push_data;
            else
                sdata_reg <= push_data;
        end
    end

endmodule

// File: rtl/websocket_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// Byte-serial WebSocket frame parser: header, length, mask key, unmasking.
// ----------------------------------------------------------------------------
// One received byte is taken per cycle and parsed in the same cycle; its
// result, if any, is held in the result register or, while that is full, in
// the skid entry. Throughput is one byte per clock while results are taken; a
// two-entry result buffer (result register plus skid entry) sets the limit,
// and in_ready drops only when both entries hold untaken results. After an
// error result all further bytes are dropped until reset.
module websocket_frame_deframer_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  rx_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  kind,
    output logic [1:0]                  frame_type,
    output logic [7:0]                  data_byte,
    output logic                        last,
    output logic [wsfd_pkg::FLEN_W-1:0] frame_length,
    output logic [15:0]                 close_code,
    output logic                        fault_code
);
    import wsfd_pkg::*;

    logic    accept;
    logic    res_valid;
    result_t res;
    result_t out_data;

    assign accept = in_valid & in_ready;

    wsfd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    wsfd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept & res_valid),
        .push_data (res),
        .room      (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign kind         = out_data.kind;
    assign frame_type   = out_data.frame_type;
    assign data_byte    = out_data.data_byte;
    assign last         = out_data.last;
    assign frame_length = out_data.frame_length;
    assign close_code   = out_data.close_code;
    assign fault_code   = out_data.fault_code;

endmodule

// File: rtl/wsfd_checker.sv
// ----------------------------------------------------------------------------
// wsfd_checker
// Port-level checks on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module wsfd_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [1:0]                  kind,
    input logic [1:0]                  frame_type,
    input logic [7:0]                  data_byte,
    input logic                        last,
    input logic [wsfd_pkg::FLEN_W-1:0] frame_length,
    input logic [15:0]                 close_code,
    input logic                        fault_code
);
    import wsfd_pkg::*;

    // stalled transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data_byte)
            && $stable(frame_length) && $stable(close_code))
        else $error("output transaction changed while stalled");

    // back-pressure only with a result pending
    a_ready_backed: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

    a_close_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_CLOSE |-> frame_type == FT_TEXT && !last
            && frame_length == '0 && data_byte == 8'h00 && !fault_code)
        else $error("close result carries stray fields");

    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_DATA |-> frame_length == '0 && close_code == 16'h0000
            && (frame_type == FT_TEXT || frame_type == FT_PING))
        else $error("payload result malformed");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ERROR |-> frame_type == FT_TEXT && !last
            && frame_length == '0 && close_code == 16'h0000)
        else $error("error result carries stray fields");

endmodule

bind websocket_frame_deframer_top wsfd_checker u_wsfd_checker (.*);
